>>> sv/uv_sphere_vertex_generator_defines.svh
// assertion macros shared by the uv sphere vertex generator modules
// expects clk and rst in the scope of each use
`ifndef UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH
`define UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH

// same-cycle implication
`define UVS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uvs check failed");

// next-cycle implication
`define UVS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uvs check failed");

`endif

>>> sv/uvs_pkg.sv
// types, constants and helper functions of the uv sphere vertex generator
// no dependencies
package uvs_pkg;

  localparam int CNT_W = 9;
  localparam int IDX_W = 17;
  localparam int FRAC_W = 17;
  localparam int RAD_W = 16;
  localparam int XW = 34;
  localparam int CORDIC_STEPS = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int REG_IDX_W = 2;

  localparam int DEF_MAX_SEGMENTS = 256;
  localparam int DEF_MAX_RINGS = 256;
  localparam int DEF_SINE_TABLE_BITS = 10;

  localparam logic [CNT_W-1:0] MIN_SEGMENTS = 9'd3;
  localparam logic [CNT_W-1:0] MIN_RINGS = 9'd2;
  localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  localparam logic [RAD_W-1:0] RST_RADIUS = 16'd256;
  localparam logic [CNT_W-1:0] RST_SEGMENTS = 9'd16;
  localparam logic [CNT_W-1:0] RST_RINGS = 9'd8;

  localparam logic [REG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SEGMENTS = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RINGS = 2'd2;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  typedef struct packed {
    logic [RAD_W-1:0] radius;
    logic [CNT_W-1:0] segs;
    logic [CNT_W-1:0] rings;
  } geom_t;

  typedef struct packed {
    logic [CNT_W-1:0] ring;
    logic [CNT_W-1:0] seg;
    logic [IDX_W-1:0] point_index;
    logic [IDX_W-1:0] below_index;
    logic has_quad;
    logic out_of_grid;
  } qitem_t;

  typedef struct packed {
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [IDX_W-1:0] point_index;
    logic [IDX_W-1:0] below_index;
    logic has_quad;
    logic out_of_grid;
  } side_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [XW-1:0] atan_turn(input int i);
    case (i)
      0: return 34'sd536870912;
      1: return 34'sd316933406;
      2: return 34'sd167458907;
      3: return 34'sd85004756;
      4: return 34'sd42667331;
      5: return 34'sd21354465;
      6: return 34'sd10679838;
      7: return 34'sd5340245;
      8: return 34'sd2670163;
      9: return 34'sd1335087;
      10: return 34'sd667544;
      11: return 34'sd333772;
      12: return 34'sd166886;
      13: return 34'sd83443;
      14: return 34'sd41722;
      15: return 34'sd20861;
      16: return 34'sd10430;
      17: return 34'sd5215;
      18: return 34'sd2608;
      19: return 34'sd1304;
      20: return 34'sd652;
      21: return 34'sd326;
      22: return 34'sd163;
      23: return 34'sd81;
      default: return '0;
    endcase
  endfunction

  // q30 to q14 with clamp to [0, 1]
  function automatic logic signed [15:0] q14_from_q30(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] t;
    t = '0;
    if (!v[XW-1]) begin
      t = (v + 34'sd32768) >>> 16;
    end
    if (t > 34'sd16384) begin
      return ONE_Q14;
    end
    return t[15:0];
  endfunction

endpackage

>>> sv/uvs_front.sv
// front end: configuration registers, count clamping and grid classification
// depends on uvs_pkg
module uvs_front import uvs_pkg::*; #(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int MAX_RINGS = DEF_MAX_RINGS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [RAD_W-1:0]     cfg_data,
  input  logic [CNT_W-1:0]     ring_index,
  input  logic [CNT_W-1:0]     segment_index,
  output qitem_t               item,
  output geom_t                geom
);

  logic [RAD_W-1:0] sphere_radius;
  logic [CNT_W-1:0] segment_count;
  logic [CNT_W-1:0] ring_count;
  logic [CNT_W-1:0] segs;
  logic [CNT_W-1:0] rings;
  logic [2*CNT_W:0] point_full;
  logic [IDX_W:0]   below_full;
  logic             oog;
  logic             quad;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius <= RST_RADIUS;
      segment_count <= RST_SEGMENTS;
      ring_count <= RST_RINGS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIUS: sphere_radius <= cfg_data;
        REG_SEGMENTS: segment_count <= cfg_data[CNT_W-1:0];
        REG_RINGS: ring_count <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (segment_count < MIN_SEGMENTS) begin
      segs = MIN_SEGMENTS;
    end else if (32'(segment_count) > MAX_SEGMENTS) begin
      segs = CNT_W'(MAX_SEGMENTS);
    end else begin
      segs = segment_count;
    end
    if (ring_count < MIN_RINGS) begin
      rings = MIN_RINGS;
    end else if (32'(ring_count) > MAX_RINGS) begin
      rings = CNT_W'(MAX_RINGS);
    end else begin
      rings = ring_count;
    end
  end

  assign oog = (ring_index > rings) || (segment_index > segs);
  assign quad = (ring_index < rings) && (segment_index < segs);
  assign point_full = ring_index * ({1'b0, segs} + 1'b1) + (2*CNT_W+1)'(segment_index);
  assign below_full = (IDX_W+1)'(point_full[IDX_W-1:0]) + (IDX_W+1)'(segs) + 1'b1;

  always_comb begin
    item.ring = ring_index;
    item.seg = segment_index;
    item.out_of_grid = oog;
    item.has_quad = quad && !oog;
    item.point_index = oog ? '0 : point_full[IDX_W-1:0];
    item.below_index = (quad && !oog) ? below_full[IDX_W-1:0] : '0;
  end

  assign geom.radius = sphere_radius;
  assign geom.segs = segs;
  assign geom.rings = rings;

endmodule

>>> sv/uvs_queue.sv
// short request queue between the front end and the compute pipeline
// depends on uvs_pkg
`include "uv_sphere_vertex_generator_defines.svh"
module uvs_queue import uvs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  qitem_t push_item,
  output logic   full,
  input  logic   pop,
  output logic   valid,
  output qitem_t head
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  qitem_t        mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full = (count == (PW+1)'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign do_push = push && !full;
  assign do_pop = pop && valid;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

  `UVS_ASSERT_NOW(a_count_bound, 1'b1, count <= (PW+1)'(QUEUE_DEPTH))
  `UVS_ASSERT_NEXT(a_count_up, do_push && !do_pop, count == $past(count) + 1'b1)
  `UVS_ASSERT_NEXT(a_count_down, do_pop && !do_push, count == $past(count) - 1'b1)

endmodule

>>> sv/uvs_back.sv
// compute pipeline: dividers, two cordic rotators, products and output register
// depends on uvs_pkg
`include "uv_sphere_vertex_generator_defines.svh"
module uvs_back import uvs_pkg::*; #(
  parameter int SINE_TABLE_BITS = DEF_SINE_TABLE_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  geom_t        geom,
  input  logic         in_valid,
  input  qitem_t       in_item,
  output logic         in_pop,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [167:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser
);

  localparam int B = SINE_TABLE_BITS;
  localparam int NST = FRAC_W + 1 + 1 + CORDIC_STEPS + 3;

  logic           en;
  logic [NST-1:0] vld;

  assign en = !vld[NST-1] || m_axis_tready;
  assign in_pop = en && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  // divider stages: quotient of index / count with FRAC_W fraction bits
  qitem_t           d_item [0:FRAC_W];
  logic [CNT_W-1:0] rem_u [0:FRAC_W];
  logic [CNT_W-1:0] rem_v [0:FRAC_W];
  logic [FRAC_W:0]  quo_u [0:FRAC_W];
  logic [FRAC_W:0]  quo_v [0:FRAC_W];

  always_ff @(posedge clk) begin
    if (en) begin
      d_item[0] <= in_item;
      if (in_item.seg >= geom.segs) begin
        rem_u[0] <= in_item.seg - geom.segs;
        quo_u[0] <= (FRAC_W+1)'(1);
      end else begin
        rem_u[0] <= in_item.seg;
        quo_u[0] <= '0;
      end
      if (in_item.ring >= geom.rings) begin
        rem_v[0] <= in_item.ring - geom.rings;
        quo_v[0] <= (FRAC_W+1)'(1);
      end else begin
        rem_v[0] <= in_item.ring;
        quo_v[0] <= '0;
      end
    end
  end

  for (genvar s = 1; s <= FRAC_W; s++) begin : g_div
    logic [CNT_W:0] tu;
    logic [CNT_W:0] tv;
    logic           bu;
    logic           bv;
    assign tu = {rem_u[s-1], 1'b0};
    assign tv = {rem_v[s-1], 1'b0};
    assign bu = tu >= {1'b0, geom.segs};
    assign bv = tv >= {1'b0, geom.rings};
    always_ff @(posedge clk) begin
      if (en) begin
        d_item[s] <= d_item[s-1];
        rem_u[s] <= bu ? CNT_W'(tu - {1'b0, geom.segs}) : tu[CNT_W-1:0];
        rem_v[s] <= bv ? CNT_W'(tv - {1'b0, geom.rings}) : tv[CNT_W-1:0];
        quo_u[s] <= {quo_u[s-1][FRAC_W-1:0], bu};
        quo_v[s] <= {quo_v[s-1][FRAC_W-1:0], bv};
      end
    end
  end

  // phase quantization and rotator seeds
  logic [FRAC_W:0] fu;
  logic [FRAC_W:0] fv;
  logic [FRAC_W:0] fu1;
  logic [FRAC_W:0] fv1;
  logic [B+1:0]    tf;
  logic [B+1:0]    tf1;
  logic [B:0]      gf;
  logic [B:0]      gf1;
  logic [B-1:0]    kt;
  logic [B-1:0]    kp;

  assign fu = quo_u[FRAC_W];
  assign fv = quo_v[FRAC_W];
  assign fu1 = fu + 1'b1;
  assign fv1 = fv + 1'b1;
  assign tf = fu[FRAC_W -: B+2];
  assign tf1 = tf + 1'b1;
  assign gf = fv[FRAC_W -: B+1];
  assign gf1 = gf + 1'b1;
  assign kt = tf1[B:1];
  assign kp = gf1[B:1];

  logic signed [XW-1:0] tx [0:CORDIC_STEPS];
  logic signed [XW-1:0] ty [0:CORDIC_STEPS];
  logic signed [XW-1:0] tz [0:CORDIC_STEPS];
  logic signed [XW-1:0] px [0:CORDIC_STEPS];
  logic signed [XW-1:0] py [0:CORDIC_STEPS];
  logic signed [XW-1:0] pz [0:CORDIC_STEPS];
  logic [1:0]           tq [0:CORDIC_STEPS];
  logic [1:0]           pq [0:CORDIC_STEPS];
  logic                 t0 [0:CORDIC_STEPS];
  logic                 p0 [0:CORDIC_STEPS];
  side_t                cs [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      tx[0] <= CORDIC_GAIN;
      ty[0] <= '0;
      tz[0] <= XW'({kt[B-3:0], {(32-B){1'b0}}});
      tq[0] <= kt[B-1 -: 2];
      t0[0] <= (kt[B-3:0] == '0);
      px[0] <= CORDIC_GAIN;
      py[0] <= '0;
      pz[0] <= XW'({kp[B-3:0], {(32-B){1'b0}}});
      pq[0] <= kp[B-1 -: 2];
      p0[0] <= (kp[B-3:0] == '0);
      cs[0].tex_u <= fu1[FRAC_W:1];
      cs[0].tex_v <= fv1[FRAC_W:1];
      cs[0].point_index <= d_item[FRAC_W].point_index;
      cs[0].below_index <= d_item[FRAC_W].below_index;
      cs[0].has_quad <= d_item[FRAC_W].has_quad;
      cs[0].out_of_grid <= d_item[FRAC_W].out_of_grid;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en) begin
        if (!tz[i][XW-1]) begin
          tx[i+1] <= tx[i] - (ty[i] >>> i);
          ty[i+1] <= ty[i] + (tx[i] >>> i);
          tz[i+1] <= tz[i] - atan_turn(i);
        end else begin
          tx[i+1] <= tx[i] + (ty[i] >>> i);
          ty[i+1] <= ty[i] - (tx[i] >>> i);
          tz[i+1] <= tz[i] + atan_turn(i);
        end
        if (!pz[i][XW-1]) begin
          px[i+1] <= px[i] - (py[i] >>> i);
          py[i+1] <= py[i] + (px[i] >>> i);
          pz[i+1] <= pz[i] - atan_turn(i);
        end else begin
          px[i+1] <= px[i] + (py[i] >>> i);
          py[i+1] <= py[i] - (px[i] >>> i);
          pz[i+1] <= pz[i] + atan_turn(i);
        end
        tq[i+1] <= tq[i];
        pq[i+1] <= pq[i];
        t0[i+1] <= t0[i];
        p0[i+1] <= p0[i];
        cs[i+1] <= cs[i];
      end
    end
  end

  // q14 conversion and quadrant fold
  logic signed [15:0] tqc;
  logic signed [15:0] tqs;
  logic signed [15:0] pqc;
  logic signed [15:0] pqs;
  logic signed [15:0] ct_n;
  logic signed [15:0] st_n;
  logic signed [15:0] cp_n;
  logic signed [15:0] sp_n;

  assign tqc = t0[CORDIC_STEPS] ? ONE_Q14 : q14_from_q30(tx[CORDIC_STEPS]);
  assign tqs = t0[CORDIC_STEPS] ? 16'sd0 : q14_from_q30(ty[CORDIC_STEPS]);
  assign pqc = p0[CORDIC_STEPS] ? ONE_Q14 : q14_from_q30(px[CORDIC_STEPS]);
  assign pqs = p0[CORDIC_STEPS] ? 16'sd0 : q14_from_q30(py[CORDIC_STEPS]);

  always_comb begin
    case (tq[CORDIC_STEPS])
      QUAD_0: begin ct_n = tqc; st_n = tqs; end
      QUAD_1: begin ct_n = -tqs; st_n = tqc; end
      QUAD_2: begin ct_n = -tqc; st_n = -tqs; end
      default: begin ct_n = tqs; st_n = -tqc; end
    endcase
    case (pq[CORDIC_STEPS])
      QUAD_0: begin cp_n = pqc; sp_n = pqs; end
      QUAD_1: begin cp_n = -pqs; sp_n = pqc; end
      QUAD_2: begin cp_n = -pqc; sp_n = -pqs; end
      default: begin cp_n = pqs; sp_n = -pqc; end
    endcase
  end

  logic signed [15:0] ct_r;
  logic signed [15:0] st_r;
  logic signed [15:0] cp_r;
  logic signed [15:0] sp_r;
  side_t              fs_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ct_r <= ct_n;
      st_r <= st_n;
      cp_r <= cp_n;
      sp_r <= sp_n;
      fs_r <= cs[CORDIC_STEPS];
    end
  end

  // first products
  logic signed [31:0] mxc;
  logic signed [31:0] mzc;
  logic signed [16:0] rad_s;
  logic signed [29:0] nx_p;
  logic signed [29:0] nz_p;
  logic signed [32:0] ry_p;
  logic signed [15:0] cp_m;
  side_t              ms_r;

  assign mxc = sp_r * ct_r;
  assign mzc = sp_r * st_r;
  assign rad_s = $signed({1'b0, geom.radius});

  always_ff @(posedge clk) begin
    if (en) begin
      nx_p <= mxc[29:0];
      nz_p <= mzc[29:0];
      ry_p <= rad_s * cp_r;
      cp_m <= cp_r;
      ms_r <= fs_r;
    end
  end

  // radius products, rounding and output register
  logic signed [46:0] rx_m;
  logic signed [46:0] rz_m;
  logic signed [46:0] rx_r;
  logic signed [46:0] rz_r;
  logic signed [32:0] ry_r;
  logic signed [29:0] nx_r;
  logic signed [29:0] nz_r;

  assign rx_m = rad_s * nx_p;
  assign rz_m = rad_s * nz_p;
  assign rx_r = rx_m + 47'sd134217728;
  assign rz_r = rz_m + 47'sd134217728;
  assign ry_r = ry_p + 33'sd8192;
  assign nx_r = nx_p + 30'sd8192;
  assign nz_r = nz_p + 30'sd8192;

  logic [16:0]      pos_x;
  logic [16:0]      pos_y;
  logic [16:0]      pos_z;
  logic [15:0]      norm_x;
  logic [15:0]      norm_y;
  logic [15:0]      norm_z;
  logic [16:0]      tex_u;
  logic [16:0]      tex_v;
  logic [IDX_W-1:0] point_index;
  logic [IDX_W-1:0] below_index;
  logic             has_quad;
  logic             out_of_grid;

  always_ff @(posedge clk) begin
    if (en) begin
      out_of_grid <= ms_r.out_of_grid;
      has_quad <= ms_r.has_quad;
      point_index <= ms_r.point_index;
      below_index <= ms_r.below_index;
      if (ms_r.out_of_grid) begin
        pos_x <= '0;
        pos_y <= '0;
        pos_z <= '0;
        norm_x <= '0;
        norm_y <= '0;
        norm_z <= '0;
        tex_u <= '0;
        tex_v <= '0;
      end else begin
        pos_x <= rx_r[44:28];
        pos_y <= ry_r[30:14];
        pos_z <= rz_r[44:28];
        norm_x <= nx_r[29:14];
        norm_y <= cp_m;
        norm_z <= nz_r[29:14];
        tex_u <= ms_r.tex_u;
        tex_v <= ms_r.tex_v;
      end
    end
  end

  assign m_axis_tvalid = vld[NST-1];
  assign m_axis_tdata = {1'b0, below_index, point_index, tex_v, tex_u,
                         norm_z, norm_y, norm_x, pos_z, pos_y, pos_x};
  assign m_axis_tuser = {out_of_grid, has_quad};

  `UVS_ASSERT_NOW(a_oog_zero, m_axis_tvalid && out_of_grid,
                  pos_x == '0 && norm_y == '0 && tex_u == '0 && point_index == '0)
  `UVS_ASSERT_NOW(a_quad_in_grid, m_axis_tvalid && has_quad, !out_of_grid)
  `UVS_ASSERT_NEXT(a_hold_on_stall, !en, vld == $past(vld))

endmodule

>>> sv/uv_sphere_vertex_generator.sv
// UV sphere vertex generator: takes one grid point (ring, segment) per request and
// returns its position, unit normal, texture coordinates and vertex indices. It takes
// one request in and one result out per clock unless the output stalls, which holds the
// whole pipeline. A request passes a four-entry queue, then the compute pipeline (18
// divider stages, a phase stage, 24 cordic stages per angle side by side, three stages
// of products and rounding). The user must write registers only while no request is in
// flight; this is not enforced. Depends on uvs_pkg, uvs_front, uvs_queue, uvs_back.
module uv_sphere_vertex_generator import uvs_pkg::*; #(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int MAX_RINGS = DEF_MAX_RINGS,
  parameter int SINE_TABLE_BITS = DEF_SINE_TABLE_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [RAD_W-1:0]     cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,  // ring_index, segment_index, zero pad
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v, point_index,
  // below_index, zero pad
  output logic [167:0]         m_axis_tdata,
  output logic [1:0]           m_axis_tuser   // has_quad, out_of_grid
);

  qitem_t f_item;
  qitem_t q_head;
  geom_t  geom;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;

  assign s_axis_tready = !q_full;

  uvs_front #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .MAX_RINGS    (MAX_RINGS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .ring_index    (s_axis_tdata[8:0]),
    .segment_index (s_axis_tdata[17:9]),
    .item          (f_item),
    .geom          (geom)
  );

  uvs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_axis_tvalid),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  uvs_back #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .geom          (geom),
    .in_valid      (q_valid),
    .in_item       (q_head),
    .in_pop        (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
